/* sv/buddy_block_allocator_assert.svh */
// Assertion macros used by the checker file
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
// Implication checked every clock, quiet during reset
`define BBA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);
// Next-cycle implication
`define BBA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);
`endif

/* sv/bba_pkg.sv */
package bba_pkg;
	localparam int NumBlocksDef = 1024;
	localparam int MaxOrdersDef = 11;
	localparam int CfgW = 11;

	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_ALLOC  = 2'd1;
	localparam logic [1:0] CMD_FREE   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] order;
		logic [9:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] granted_block;
	} out_item_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT_CLR,
		S_INIT_CHUNK,
		S_AL_CHECK,
		S_AL_POPRD,
		S_AL_POPWR,
		S_AL_SCAN,
		S_AL_SPRD,
		S_AL_SPWR1,
		S_AL_SPWR2,
		S_FR_START,
		S_FR_RD,
		S_FR_CMP,
		S_FR_UNRD,
		S_FR_UNWR,
		S_FR_PUSH,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // capture input item
		logic init_start;  // clamp total, set counts, clear heads
		logic init_chunk;  // push one chunk of init
		logic scan_start;  // scan_ord <= ord + 1
		logic scan_inc;
		logic rd_head;     // read link of head[ord]
		logic rd_scan;     // read link of head[scan_ord]
		logic pop_wr;      // head[ord] <= rdata, link[r] <= 0, grant r
		logic split_wr1;   // head[scan] <= rdata, link[p1] <= p2
		logic split_wr2;   // link[p2] <= head[scan-1], head[scan-1] <= p1
		logic fr_start;    // prev <= 0, cur <= head[ord], steps <= 0
		logic fr_rd;       // read link of cur
		logic fr_adv;      // prev <= cur, cur <= rdata, steps++
		logic un_rd;       // read link of cur (for unlink)
		logic un_wr;       // unlink cur, merge, ord++
		logic push_wr;     // link[sp] <= head[ord], head[ord] <= sp
		logic set_stat;
		logic [1:0] stat;
	} cmd_t;

	// datapath status to controller
	typedef struct packed {
		logic [1:0] command;
		logic ord_bad;     // ord >= order_count
		logic sp_bad;      // free of block 0 or beyond range
		logic rem_zero;
		logic head_nz;     // head[ord] != 0
		logic scan_end;    // scan_ord >= order_count
		logic scan_nz;     // head[scan_ord] != 0
		logic cur_zero;
		logic steps_end;
		logic match;       // buddy found at cur (needs link read)
		logic ord_top;     // ord >= order_count
	} stat_t;
endpackage

/* sv/bba_datapath.sv */
module bba_datapath #(
	parameter int NUM_BLOCKS = bba_pkg::NumBlocksDef,
	parameter int MAX_ORDERS = bba_pkg::MaxOrdersDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bba_pkg::CfgW-1:0] total_blocks,
	input  bba_pkg::in_item_t        in_item,
	input  bba_pkg::cmd_t            cmd,
	output bba_pkg::stat_t           stat,
	output bba_pkg::out_item_t       res
);
	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int OW = $clog2(MAX_ORDERS + 1);
	localparam int TW = IW + 1;
	localparam int SW = IW + 1;

	logic [IW-1:0] link_mem [NUM_BLOCKS];
	logic [IW-1:0] heads_q [MAX_ORDERS];
	logic [IW-1:0] rdata_q;
	logic [1:0]    command_q;
	logic [OW-1:0] ord_q, scan_q, oc_q;
	logic [3:0]    ord_in_q;
	logic [IW-1:0] sp_q, cur_q, prev_q;
	logic [TW-1:0] rem_q, start_q;
	logic [SW-1:0] steps_q;
	logic [1:0]    stat_q;
	logic [IW-1:0] grant_q;
	logic          sp_big_q;
	logic          found2_q;

	// helpers
	logic [TW-1:0] tot_c;
	logic [OW-1:0] oc_c;
	logic [OW-1:0] k_c;
	logic [TW-1:0] size_c;
	logic [IW-1:0] addr_c;
	logic [IW-1:0] head_ord, head_scan, head_scm1, bsz, p2_c;
	logic [TW-1:0] len2, num2;
	logic          m1, m2, ali1, ali2;
	logic [OW-1:0] scm1;

	// clamp of the register
	always_comb begin
		logic [TW:0] t;
		t = {{(TW + 1 - bba_pkg::CfgW){1'b0}}, total_blocks};
		if (t < (TW + 1)'(2)) t = (TW + 1)'(2);
		if (t > (TW + 1)'(NUM_BLOCKS)) t = (TW + 1)'(NUM_BLOCKS);
		tot_c = t[TW-1:0];
		oc_c = '0;
		for (int b = 0; b < TW; b++)
			if (((tot_c - TW'(1)) >> b) != '0) oc_c = OW'(b + 1);
		if (oc_c > OW'(MAX_ORDERS)) oc_c = OW'(MAX_ORDERS);
	end

	// largest chunk order for rem
	always_comb begin
		k_c = '0;
		for (int b = 1; b < MAX_ORDERS; b++)
			if ((rem_q >> b) != '0) k_c = OW'(b);
		size_c = TW'(1) << k_c;
		addr_c = IW'(TW'(1) + rem_q - size_c);
	end

	// grant_q holds p1 while a split is in progress
	assign scm1      = scan_q - OW'(1);
	assign head_ord  = heads_q[ord_q[OW-1:0] < OW'(MAX_ORDERS) ? ord_q : '0];
	assign head_scan = heads_q[scan_q < OW'(MAX_ORDERS) ? scan_q : '0];
	assign head_scm1 = heads_q[scm1 < OW'(MAX_ORDERS) ? scm1 : '0];
	assign bsz       = IW'(TW'(1) << ord_q);
	assign p2_c      = IW'(grant_q + IW'(TW'(1) << scm1));

	// buddy tests at order ord+1
	always_comb begin
		logic [TW:0] msk;
		msk  = ((TW + 1)'(1) << (ord_q + OW'(1))) - (TW + 1)'(1);
		len2 = TW'(msk);
		num2 = TW'(((start_q - TW'(1)) & len2) + TW'(1)) & len2;
		m1   = (cur_q == IW'(sp_q + bsz));
		m2   = (sp_q == IW'(cur_q + bsz));
		ali1 = ((TW'(sp_q) & len2) == num2);
		ali2 = ((TW'(cur_q) & len2) == num2);
	end

	assign stat.command   = command_q;
	assign stat.ord_bad   = ({{OW{1'b0}}, ord_in_q} >= {4'b0, oc_q});
	assign stat.sp_bad    = (sp_q == '0) || sp_big_q;
	assign stat.rem_zero  = (rem_q == '0);
	assign stat.head_nz   = (head_ord != '0);
	assign stat.scan_end  = (scan_q >= oc_q);
	assign stat.scan_nz   = (head_scan != '0);
	assign stat.cur_zero  = (cur_q == '0);
	assign stat.steps_end = (steps_q >= SW'(NUM_BLOCKS));
	assign stat.match     = (m1 && ali1) || (!m1 && m2 && ali2);
	assign stat.ord_top   = (ord_q >= oc_q);

	// link memory: one write port, one registered read port held between reads
	always_ff @(posedge clk) begin
		logic [IW-1:0] ra;
		ra = cur_q;
		if (cmd.rd_head) ra = head_ord;
		if (cmd.rd_scan) ra = head_scan;
		if (cmd.rd_head || cmd.rd_scan || cmd.fr_rd || cmd.un_rd)
			rdata_q <= link_mem[ra];
		if (cmd.init_chunk)
			link_mem[addr_c] <= heads_q[k_c];
		else if (cmd.pop_wr)
			link_mem[head_ord] <= '0;
		else if (cmd.split_wr1)
			link_mem[head_scan] <= p2_c;
		else if (cmd.split_wr2)
			link_mem[p2_c] <= head_scm1;
		else if (cmd.un_wr && prev_q != '0)
			link_mem[prev_q] <= rdata_q;
		else if (cmd.push_wr)
			link_mem[sp_q] <= head_ord;
	end

	// control and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDERS; i++) heads_q[i] <= '0;
			oc_q    <= '0;
			start_q <= '0;
		end else begin
			if (cmd.init_start) begin
				for (int i = 0; i < MAX_ORDERS; i++) heads_q[i] <= '0;
				oc_q    <= oc_c;
				start_q <= tot_c;
			end
			if (cmd.init_chunk) heads_q[k_c] <= addr_c;
			if (cmd.pop_wr) heads_q[ord_q] <= rdata_q;
			if (cmd.split_wr1) heads_q[scan_q] <= rdata_q;
			if (cmd.split_wr2) heads_q[scm1] <= grant_q;
			if (cmd.un_wr && prev_q == '0) heads_q[ord_q] <= rdata_q;
			if (cmd.push_wr) heads_q[ord_q] <= sp_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= in_item.command;
			ord_in_q  <= in_item.order;
			ord_q     <= OW'(in_item.order);
			sp_q      <= in_item.block_index[IW-1:0];
			sp_big_q  <= ({6'b0, in_item.block_index} >= 16'(NUM_BLOCKS));
			grant_q   <= '0;
			stat_q    <= bba_pkg::ST_OK;
		end
		if (cmd.init_start) rem_q <= tot_c - TW'(1);
		if (cmd.init_chunk) rem_q <= rem_q - size_c;
		if (cmd.scan_start) scan_q <= ord_q + OW'(1);
		if (cmd.scan_inc) scan_q <= scan_q + OW'(1);
		if (cmd.rd_scan) grant_q <= head_scan;
		if (cmd.pop_wr) grant_q <= head_ord;
		if (cmd.fr_start) begin
			prev_q  <= '0;
			cur_q   <= head_ord;
			steps_q <= '0;
		end
		if (cmd.fr_adv) begin
			prev_q  <= cur_q;
			cur_q   <= rdata_q;
			steps_q <= steps_q + SW'(1);
		end
		if (cmd.un_rd) found2_q <= !m1;
		if (cmd.un_wr) begin
			if (found2_q) sp_q <= cur_q;
			ord_q <= ord_q + OW'(1);
		end
		if (cmd.set_stat) stat_q <= cmd.stat;
	end

	assign res.status        = stat_q;
	assign res.granted_block = 10'(grant_q);
endmodule

/* sv/bba_ctrl.sv */
module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                cfg_ready,
	input  bba_pkg::stat_t      stat,
	output bba_pkg::cmd_t       cmd
);
	bba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bba_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::S_IDLE: if (in_valid) state_d = bba_pkg::S_AL_CHECK;
			bba_pkg::S_AL_CHECK: begin
				case (stat.command)
					bba_pkg::CMD_INIT:  state_d = bba_pkg::S_INIT_CLR;
					bba_pkg::CMD_ALLOC: state_d = stat.ord_bad ? bba_pkg::S_DONE :
						(stat.head_nz ? bba_pkg::S_AL_POPRD : bba_pkg::S_AL_SCAN);
					bba_pkg::CMD_FREE:  state_d = (stat.ord_bad || stat.sp_bad) ?
						bba_pkg::S_DONE : bba_pkg::S_FR_START;
					default: state_d = bba_pkg::S_DONE;
				endcase
			end
			bba_pkg::S_INIT_CLR: state_d = bba_pkg::S_INIT_CHUNK;
			bba_pkg::S_INIT_CHUNK: if (stat.rem_zero) state_d = bba_pkg::S_DONE;
			bba_pkg::S_AL_POPRD: state_d = bba_pkg::S_AL_POPWR;
			bba_pkg::S_AL_POPWR: state_d = bba_pkg::S_DONE;
			bba_pkg::S_AL_SCAN: begin
				if (stat.scan_end) state_d = bba_pkg::S_DONE;
				else if (stat.scan_nz) state_d = bba_pkg::S_AL_SPRD;
			end
			bba_pkg::S_AL_SPRD: state_d = bba_pkg::S_AL_SPWR1;
			bba_pkg::S_AL_SPWR1: state_d = bba_pkg::S_AL_SPWR2;
			bba_pkg::S_AL_SPWR2: state_d = bba_pkg::S_AL_CHECK;
			// merge past the top order drops the chunk
			bba_pkg::S_FR_START: state_d = stat.ord_top ? bba_pkg::S_DONE : bba_pkg::S_FR_RD;
			bba_pkg::S_FR_RD: begin
				if (stat.cur_zero || stat.steps_end) state_d = bba_pkg::S_FR_PUSH;
				else state_d = bba_pkg::S_FR_CMP;
			end
			bba_pkg::S_FR_CMP: state_d = stat.match ? bba_pkg::S_FR_UNWR : bba_pkg::S_FR_RD;
			bba_pkg::S_FR_UNRD: state_d = bba_pkg::S_FR_UNWR;
			bba_pkg::S_FR_UNWR: state_d = bba_pkg::S_FR_START;
			bba_pkg::S_FR_PUSH: state_d = bba_pkg::S_DONE;
			bba_pkg::S_DONE: if (!out_stall) state_d = bba_pkg::S_IDLE;
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall  = (state_q != bba_pkg::S_IDLE);
		out_valid = (state_q == bba_pkg::S_DONE);
		cfg_ready = (state_q == bba_pkg::S_IDLE);
		unique case (state_q)
			bba_pkg::S_IDLE: cmd.load = in_valid;
			bba_pkg::S_AL_CHECK: begin
				if (stat.command == bba_pkg::CMD_INIT) cmd.init_start = 1'b1;
				if (stat.command == bba_pkg::CMD_ALLOC) begin
					if (stat.ord_bad) begin
						cmd.set_stat = 1'b1;
						cmd.stat = bba_pkg::ST_ORDER;
					end else if (stat.head_nz) cmd.rd_head = 1'b1;
					else cmd.scan_start = 1'b1;
				end
				if (stat.command == bba_pkg::CMD_FREE && stat.ord_bad) begin
					cmd.set_stat = 1'b1;
					cmd.stat = bba_pkg::ST_ORDER;
				end
			end
			bba_pkg::S_INIT_CHUNK: cmd.init_chunk = !stat.rem_zero;
			bba_pkg::S_AL_POPWR: cmd.pop_wr = 1'b1;
			bba_pkg::S_AL_SCAN: begin
				if (stat.scan_end) begin
					cmd.set_stat = 1'b1;
					cmd.stat = bba_pkg::ST_EMPTY;
				end else if (stat.scan_nz) cmd.rd_scan = 1'b1;
				else cmd.scan_inc = 1'b1;
			end
			bba_pkg::S_AL_SPWR1: cmd.split_wr1 = 1'b1;
			bba_pkg::S_AL_SPWR2: cmd.split_wr2 = 1'b1;
			bba_pkg::S_FR_START: cmd.fr_start = !stat.ord_top;
			bba_pkg::S_FR_RD: cmd.fr_rd = 1'b1;
			bba_pkg::S_FR_CMP: begin
				if (stat.match) cmd.un_rd = 1'b1;
				else cmd.fr_adv = 1'b1;
			end
			bba_pkg::S_FR_UNWR: cmd.un_wr = 1'b1;
			bba_pkg::S_FR_PUSH: cmd.push_wr = 1'b1;
			default: ;
		endcase
	end
endmodule

/* sv/buddy_block_allocator.sv */
// Buddy allocator over block indices; block 0 is reserved and 0 means null.
// Input channel in_valid/in_stall carries one command item (init, alloc,
// free); output channel out_valid/out_stall returns one result item per
// command with status and granted block.
// The config channel cfg_valid/cfg_ready writes total_blocks; it is ready
// only while no command is in progress and is used by the next init.
// An order error, a free of block 0 or the unused command goes straight from the
// check to the result. Alloc from a non-empty list reads and pops its head; each
// split scans past the empty orders, reads the found list, writes twice and
// checks again. Free compares each list entry, unlinks and merges on a match and
// then pushes. Init clears the heads and pushes one chunk at a time. All of it is
// bound by the single write and read ports of the link memory and the single
// controller, one item at a time. The result waits in its register while
// out_stall is high; the next item is taken the cycle after the result leaves.
// Reset clears the free-list heads and order count, so every alloc or free
// before the first init reports an order error. Links need no clearing.
module buddy_block_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NumBlocksDef,
	parameter int MAX_ORDERS = bba_pkg::MaxOrdersDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  bba_pkg::in_item_t        in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bba_pkg::out_item_t       out_item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [bba_pkg::CfgW-1:0] cfg_data
);
	logic [bba_pkg::CfgW-1:0] total_q;
	bba_pkg::cmd_t  cmd;
	bba_pkg::stat_t stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) total_q <= bba_pkg::CfgW'(1024);
		else if (cfg_valid && cfg_ready) total_q <= cfg_data;
	end

	bba_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.cfg_ready, .stat, .cmd
	);

	bba_datapath #(.NUM_BLOCKS(NUM_BLOCKS), .MAX_ORDERS(MAX_ORDERS)) u_dp (
		.clk, .arst_n, .total_blocks(total_q), .in_item, .cmd, .stat,
		.res(out_item)
	);
endmodule

/* sv/bba_checker.sv */
`include "buddy_block_allocator_assert.svh"
module bba_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input bba_pkg::out_item_t out_item,
	input logic               out_valid,
	input logic               out_stall,
	input logic               cfg_ready
);
	`BBA_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, in_stall, "input taken with result pending")
	`BBA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "result dropped")
	`BBA_ASSERT_IMP(a_cfg, clk, arst_n, cfg_ready, !in_stall, "config while busy")
	`BBA_ASSERT_IMP(a_grant, clk, arst_n, out_valid && out_item.status != bba_pkg::ST_OK, out_item.granted_block == '0, "grant with error")
endmodule

bind buddy_block_allocator bba_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_item, .out_valid, .out_stall, .cfg_ready
);
